/* rtl/core/btok_pkg.sv */
// ----------------------------------------------------------------------------
// Token scanner package
// Shared types, token codes, character codes and the keyword table.
// ----------------------------------------------------------------------------
package btok_pkg;

   // Longest string the scanner counts, and the cap of its length counter.
   localparam int MAX_TEXT   = 256;
   localparam int STR_LEN_W  = 9;
   localparam int STR_CAP    = ((MAX_TEXT - 1) < 511) ? (MAX_TEXT - 1) : 511;

   localparam int VALUE_W    = 31;
   localparam logic [VALUE_W-1:0] NUM_MAX = {VALUE_W{1'b1}};

   // Depth of the record queue between the front and the back.
   localparam int QUEUE_DEPTH = 4;
   localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
   localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

   // Word buffer and keyword table.
   localparam int WORD_CHARS  = 6;
   localparam int KW_COUNT    = 12;
   localparam logic [2:0] WORD_TOO_LONG = 3'd7;

   typedef enum logic [2:0] {
      MODE_IDLE,
      MODE_LT,
      MODE_GT,
      MODE_WORD,
      MODE_NUM,
      MODE_STR
   } scan_mode_type;

   typedef enum logic [4:0] {
      TK_EOL    = 5'd0,
      TK_IDENT  = 5'd1,
      TK_INT    = 5'd2,
      TK_STREND = 5'd3,
      TK_STRCH  = 5'd4,
      TK_PRINT  = 5'd5,
      TK_GT     = 5'd17,
      TK_GE     = 5'd18,
      TK_LT     = 5'd19,
      TK_LE     = 5'd20,
      TK_EQ     = 5'd21,
      TK_NE     = 5'd22,
      TK_PLUS   = 5'd23,
      TK_MINUS  = 5'd24,
      TK_MUL    = 5'd25,
      TK_DIV    = 5'd26,
      TK_LPAREN = 5'd27,
      TK_RPAREN = 5'd28,
      TK_COMMA  = 5'd29,
      TK_ERROR  = 5'd30
   } token_code_type;

   // Source characters with a meaning of their own.
   localparam logic [7:0] CH_TAB    = 8'h09;
   localparam logic [7:0] CH_NL     = 8'h0A;
   localparam logic [7:0] CH_SPACE  = 8'h20;
   localparam logic [7:0] CH_QUOTE  = 8'h22;
   localparam logic [7:0] CH_LPAREN = 8'h28;
   localparam logic [7:0] CH_RPAREN = 8'h29;
   localparam logic [7:0] CH_STAR   = 8'h2A;
   localparam logic [7:0] CH_PLUS   = 8'h2B;
   localparam logic [7:0] CH_COMMA  = 8'h2C;
   localparam logic [7:0] CH_MINUS  = 8'h2D;
   localparam logic [7:0] CH_SLASH  = 8'h2F;
   localparam logic [7:0] CH_ZERO   = 8'h30;
   localparam logic [7:0] CH_LESS   = 8'h3C;
   localparam logic [7:0] CH_EQUAL  = 8'h3D;
   localparam logic [7:0] CH_GREAT  = 8'h3E;
   localparam logic [7:0] CH_UPPER_A = 8'h41;
   localparam logic [7:0] CASE_GAP  = 8'h20;

   // Keywords, left aligned and padded with zero bytes; codes count up from TK_PRINT.
   localparam logic [8*WORD_CHARS-1:0] KW_TEXT [KW_COUNT] = '{
      {"PRINT", 8'h00}, {"IF", 32'h0}, {"THEN", 16'h0}, {"GOTO", 16'h0},
      {"INPUT", 8'h00}, {"LET", 24'h0}, {"GOSUB", 8'h00}, {"RETURN"},
      {"CLEAR", 8'h00}, {"LIST", 16'h0}, {"RUN", 24'h0}, {"END", 24'h0}
   };
   localparam logic [2:0] KW_LEN [KW_COUNT] = '{
      3'd5, 3'd2, 3'd4, 3'd4, 3'd5, 3'd3, 3'd5, 3'd6, 3'd5, 3'd4, 3'd3, 3'd3
   };

   typedef struct packed {
      logic [4:0]         code;
      logic [VALUE_W-1:0] value;
      logic               overflow;
   } scan_token_type;

   // Everything one source byte produces: one token, or two when 'two' is set.
   typedef struct packed {
      logic           two;
      scan_token_type tok_a;
      scan_token_type tok_b;
   } record_type;

   typedef struct packed {
      logic full;
      logic empty;
   } queue_status_type;

endpackage

/* rtl/core/basic_token_scanner_unit.sv */
// ----------------------------------------------------------------------------
// Tiny BASIC token scanner
// Turns source bytes into tokens, one byte per cycle while req_full is low.
// ----------------------------------------------------------------------------
// Usage. Source bytes are written like pushes into a queue: req_ch is taken
// at a rising edge with req_push high and req_full low. Tokens are read like
// pops from a queue: while rsp_empty is low the oldest token sits on the
// rsp_ ports and it is taken at an edge with rsp_pop high. A byte gives no,
// one or two tokens; rsp_last marks the last token due to a byte.
// A byte is taken and its record written into the queue at the same edge;
// its first token moves into the output register that drives the rsp_ ports
// once the record is at the queue head and that register is free. Words,
// numbers and '<' or '>' are completed only by the byte that follows them.
// Throughput: one byte per cycle while req_full is low; the output side
// gives one token per cycle while rsp_pop is held, so bytes that give two
// tokens lower the sustained rate to match. Scanner state updates on each
// accepted byte; a four-record queue decouples it from the output register.
// Stalls: when the reader holds off, records pile up in the queue and
// req_full rises once it holds four records. Reset clears the scan state,
// the queue and the output register; no token is pending after reset.
// ----------------------------------------------------------------------------
module basic_token_scanner_unit (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_push,
   output logic        req_full,
   input  logic [7:0]  req_ch,
   output logic        rsp_empty,
   input  logic        rsp_pop,
   output logic [4:0]  rsp_token_code,
   output logic [30:0] rsp_token_value,
   output logic        rsp_overflow,
   output logic        rsp_last
);

   logic                           accept;
   logic                           rec_valid;
   btok_pkg::record_type           rec;
   btok_pkg::record_type           head_rec;
   btok_pkg::queue_status_type     q_status;
   logic                           q_pop;
   logic                           out_valid;
   btok_pkg::scan_token_type       out_tok;

   // A byte is taken whenever the queue has room for its record.
   assign req_full = q_status.full;
   assign accept   = req_push && !q_status.full;

   btok_front u_front (
      .clock     (clock),
      .reset     (reset),
      .accept    (accept),
      .ch        (req_ch),
      .rec_valid (rec_valid),
      .rec       (rec)
   );

   // Only bytes that produced at least one token leave a record behind.
   btok_queue u_queue (
      .clock    (clock),
      .reset    (reset),
      .push     (accept && rec_valid),
      .push_rec (rec),
      .pop      (q_pop),
      .head_rec (head_rec),
      .status   (q_status)
   );

   btok_back u_back (
      .clock     (clock),
      .reset     (reset),
      .head_rec  (head_rec),
      .q_status  (q_status),
      .q_pop     (q_pop),
      .out_pop   (rsp_pop),
      .out_valid (out_valid),
      .out_tok   (out_tok),
      .out_last  (rsp_last)
   );

   assign rsp_empty       = !out_valid;
   assign rsp_token_code  = out_tok.code;
   assign rsp_token_value = out_tok.value;
   assign rsp_overflow    = out_tok.overflow;

`ifndef SYNTHESIS
   // Output register refills at once when a token is taken and records wait.
   a_refill : assert property (@(posedge clock) disable iff (reset)
      (rsp_pop && !rsp_empty && !q_status.empty) |=> !rsp_empty)
      else $error("output register not refilled from waiting record");

   // A token that is not the last of its byte leaves its record queued.
   a_pair_held : assert property (@(posedge clock) disable iff (reset)
      (!rsp_empty && !rsp_last) |-> !q_status.empty)
      else $error("second token of a record lost");

   // Reset leaves no token on the output.
   a_reset_empty : assert property (@(posedge clock)
      reset |=> rsp_empty)
      else $error("token present after reset");
`endif

endmodule

/* rtl/core/btok_front.sv */
// ----------------------------------------------------------------------------
// Token scanner front
// Takes one source byte per cycle while accept is high, tracks the scan state
// and builds the token record for that byte.
// ----------------------------------------------------------------------------
module btok_front (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   accept,
   input  logic [7:0]             ch,
   output logic                   rec_valid,
   output btok_pkg::record_type   rec
);

   btok_pkg::scan_mode_type mode_ff, mode_in;
   logic [7:0]  word_chars_ff [btok_pkg::WORD_CHARS];
   logic [2:0]  len_ff, len_in;
   logic [4:0]  first_ff, first_in;
   logic [btok_pkg::VALUE_W-1:0]   acc_ff, acc_in;
   logic        sat_ff, sat_in;
   logic [btok_pkg::STR_LEN_W-1:0] strlen_ff, strlen_in;

   logic        wr_en;
   logic [2:0]  wr_idx;
   logic        is_alpha, is_digit;
   logic [7:0]  upper_c;
   logic [4:0]  first_c;
   logic [34:0] num_next;
   logic        kw_hit;
   logic [3:0]  kw_idx;
   logic        again;
   logic        e_valid, s_valid;
   btok_pkg::scan_token_type e_tok, s_tok, word_tok;

   assign is_alpha = (ch inside {["A":"Z"], ["a":"z"]});
   assign is_digit = (ch inside {["0":"9"]});
   assign upper_c  = (ch inside {["a":"z"]}) ? (ch - btok_pkg::CASE_GAP) : ch;
   assign first_c  = 5'(upper_c - btok_pkg::CH_UPPER_A);
   // acc * 10 + digit, as two shifted copies and the digit.
   assign num_next = {1'b0, acc_ff, 3'b000} + {3'b000, acc_ff, 1'b0}
                   + {27'd0, ch - btok_pkg::CH_ZERO};

   // Keyword match: all twelve entries compared in parallel.
   always_comb begin
      logic same;
      kw_hit = 1'b0;
      kw_idx = '0;
      for (int k = btok_pkg::KW_COUNT - 1; k >= 0; k--) begin
         same = (len_ff == btok_pkg::KW_LEN[k]);
         for (int m = 0; m < btok_pkg::WORD_CHARS; m++) begin
            if (3'(m) < btok_pkg::KW_LEN[k] &&
                word_chars_ff[m] != btok_pkg::KW_TEXT[k][8*(btok_pkg::WORD_CHARS-m)-1 -: 8])
               same = 1'b0;
         end
         if (same) begin
            kw_hit = 1'b1;
            kw_idx = 4'(k);
         end
      end
   end

   always_comb begin
      word_tok.overflow = 1'b0;
      if (kw_hit) begin
         word_tok.code  = 5'(btok_pkg::TK_PRINT) + 5'(kw_idx);
         word_tok.value = '0;
      end else begin
         word_tok.code  = btok_pkg::TK_IDENT;
         word_tok.value = btok_pkg::VALUE_W'(first_ff);
      end
   end

   always_comb begin
      mode_in   = mode_ff;
      len_in    = len_ff;
      first_in  = first_ff;
      acc_in    = acc_ff;
      sat_in    = sat_ff;
      strlen_in = strlen_ff;
      wr_en     = 1'b0;
      wr_idx    = len_ff;
      again     = 1'b0;
      e_valid   = 1'b0;
      e_tok     = '0;
      s_valid   = 1'b0;
      s_tok     = '0;

      case (mode_ff)
         btok_pkg::MODE_LT: begin
            mode_in = btok_pkg::MODE_IDLE;
            e_valid = 1'b1;
            if (ch == btok_pkg::CH_EQUAL) begin
               e_tok.code = btok_pkg::TK_LE;
            end else if (ch == btok_pkg::CH_GREAT) begin
               e_tok.code = btok_pkg::TK_NE;
            end else begin
               e_tok.code = btok_pkg::TK_LT;
               again      = 1'b1;
            end
         end
         btok_pkg::MODE_GT: begin
            mode_in = btok_pkg::MODE_IDLE;
            e_valid = 1'b1;
            if (ch == btok_pkg::CH_EQUAL) begin
               e_tok.code = btok_pkg::TK_GE;
            end else begin
               e_tok.code = btok_pkg::TK_GT;
               again      = 1'b1;
            end
         end
         btok_pkg::MODE_WORD: begin
            if (is_alpha || is_digit) begin
               if (len_ff < 3'(btok_pkg::WORD_CHARS)) begin
                  wr_en  = 1'b1;
                  len_in = len_ff + 3'd1;
               end else begin
                  len_in = btok_pkg::WORD_TOO_LONG;
               end
            end else begin
               e_valid = 1'b1;
               e_tok   = word_tok;
               mode_in = btok_pkg::MODE_IDLE;
               again   = 1'b1;
            end
         end
         btok_pkg::MODE_NUM: begin
            if (is_digit) begin
               if (num_next > 35'(btok_pkg::NUM_MAX)) begin
                  acc_in = btok_pkg::NUM_MAX;
                  sat_in = 1'b1;
               end else begin
                  acc_in = num_next[btok_pkg::VALUE_W-1:0];
               end
            end else begin
               e_valid        = 1'b1;
               e_tok.code     = btok_pkg::TK_INT;
               e_tok.value    = acc_ff;
               e_tok.overflow = sat_ff;
               mode_in        = btok_pkg::MODE_IDLE;
               again          = 1'b1;
            end
         end
         btok_pkg::MODE_STR: begin
            e_valid = 1'b1;
            if (ch == btok_pkg::CH_QUOTE) begin
               e_tok.code  = btok_pkg::TK_STREND;
               e_tok.value = btok_pkg::VALUE_W'(strlen_ff);
               mode_in     = btok_pkg::MODE_IDLE;
            end else if (ch == btok_pkg::CH_NL) begin
               // Unterminated string: error with the length, then end of line.
               e_tok.code  = btok_pkg::TK_ERROR;
               e_tok.value = btok_pkg::VALUE_W'(strlen_ff);
               s_valid     = 1'b1;
               s_tok.code  = btok_pkg::TK_EOL;
               mode_in     = btok_pkg::MODE_IDLE;
            end else begin
               e_tok.code  = btok_pkg::TK_STRCH;
               e_tok.value = btok_pkg::VALUE_W'(ch);
               if (strlen_ff < btok_pkg::STR_LEN_W'(btok_pkg::STR_CAP))
                  strlen_in = strlen_ff + 1'b1;
            end
         end
         default: begin
            mode_in = btok_pkg::MODE_IDLE;
            again   = 1'b1;
         end
      endcase

      // The byte starts a new token (again after ending a pending one).
      if (again) begin
         case (ch)
            btok_pkg::CH_SPACE, btok_pkg::CH_TAB: begin
            end
            btok_pkg::CH_NL: begin
               s_valid    = 1'b1;
               s_tok.code = btok_pkg::TK_EOL;
            end
            btok_pkg::CH_LESS:  mode_in = btok_pkg::MODE_LT;
            btok_pkg::CH_GREAT: mode_in = btok_pkg::MODE_GT;
            btok_pkg::CH_EQUAL: begin
               s_valid    = 1'b1;
               s_tok.code = btok_pkg::TK_EQ;
            end
            btok_pkg::CH_PLUS: begin
               s_valid    = 1'b1;
               s_tok.code = btok_pkg::TK_PLUS;
            end
            btok_pkg::CH_MINUS: begin
               s_valid    = 1'b1;
               s_tok.code = btok_pkg::TK_MINUS;
            end
            btok_pkg::CH_STAR: begin
               s_valid    = 1'b1;
               s_tok.code = btok_pkg::TK_MUL;
            end
            btok_pkg::CH_SLASH: begin
               s_valid    = 1'b1;
               s_tok.code = btok_pkg::TK_DIV;
            end
            btok_pkg::CH_LPAREN: begin
               s_valid    = 1'b1;
               s_tok.code = btok_pkg::TK_LPAREN;
            end
            btok_pkg::CH_RPAREN: begin
               s_valid    = 1'b1;
               s_tok.code = btok_pkg::TK_RPAREN;
            end
            btok_pkg::CH_COMMA: begin
               s_valid    = 1'b1;
               s_tok.code = btok_pkg::TK_COMMA;
            end
            btok_pkg::CH_QUOTE: begin
               mode_in   = btok_pkg::MODE_STR;
               strlen_in = '0;
            end
            default: begin
               if (is_alpha) begin
                  mode_in  = btok_pkg::MODE_WORD;
                  wr_en    = 1'b1;
                  wr_idx   = 3'd0;
                  len_in   = 3'd1;
                  first_in = first_c;
               end else if (is_digit) begin
                  mode_in = btok_pkg::MODE_NUM;
                  acc_in  = btok_pkg::VALUE_W'(ch - btok_pkg::CH_ZERO);
                  sat_in  = 1'b0;
               end else begin
                  s_valid     = 1'b1;
                  s_tok.code  = btok_pkg::TK_ERROR;
                  s_tok.value = btok_pkg::VALUE_W'(ch);
               end
            end
         endcase
      end
   end

   // Pack the emitted tokens in order of emission.
   always_comb begin
      rec       = '0;
      rec_valid = e_valid || s_valid;
      if (e_valid) begin
         rec.tok_a = e_tok;
         rec.tok_b = s_tok;
         rec.two   = s_valid;
      end else begin
         rec.tok_a = s_tok;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff   <= btok_pkg::MODE_IDLE;
         len_ff    <= '0;
         first_ff  <= '0;
         acc_ff    <= '0;
         sat_ff    <= 1'b0;
         strlen_ff <= '0;
      end else if (accept) begin
         mode_ff   <= mode_in;
         len_ff    <= len_in;
         first_ff  <= first_in;
         acc_ff    <= acc_in;
         sat_ff    <= sat_in;
         strlen_ff <= strlen_in;
      end
   end

   always_ff @(posedge clock) begin
      for (int i = 0; i < btok_pkg::WORD_CHARS; i++) begin
         if (accept && wr_en && wr_idx == 3'(i))
            word_chars_ff[i] <= upper_c;
      end
   end

endmodule

/* rtl/core/btok_queue.sv */
// ----------------------------------------------------------------------------
// Token scanner record queue
// Short first-in first-out queue of token records between front and back.
// ----------------------------------------------------------------------------
module btok_queue (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           push,
   input  btok_pkg::record_type           push_rec,
   input  logic                           pop,
   output btok_pkg::record_type           head_rec,
   output btok_pkg::queue_status_type     status
);

   btok_pkg::record_type entries_ff [btok_pkg::QUEUE_DEPTH];
   logic [btok_pkg::QPTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [btok_pkg::QPTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [btok_pkg::QCNT_W-1:0] count_ff, count_in;

   assign status.full  = (count_ff == btok_pkg::QCNT_W'(btok_pkg::QUEUE_DEPTH));
   assign status.empty = (count_ff == '0);
   assign head_rec     = entries_ff[rd_ptr_ff];

   // Pointers wrap by overflow, the depth being a power of two.
   always_comb begin
      rd_ptr_in = rd_ptr_ff;
      wr_ptr_in = wr_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = rd_ptr_ff + 1'b1;
      end
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rd_ptr_ff <= '0;
         wr_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         rd_ptr_ff <= rd_ptr_in;
         wr_ptr_ff <= wr_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push)
         entries_ff[wr_ptr_ff] <= push_rec;
   end

endmodule

/* rtl/core/btok_back.sv */
// ----------------------------------------------------------------------------
// Token scanner back
// Splits queued records into single tokens and holds the output register.
// ----------------------------------------------------------------------------
module btok_back (
   input  logic                           clock,
   input  logic                           reset,
   input  btok_pkg::record_type           head_rec,
   input  btok_pkg::queue_status_type     q_status,
   output logic                           q_pop,
   input  logic                           out_pop,
   output logic                           out_valid,
   output btok_pkg::scan_token_type       out_tok,
   output logic                           out_last
);

   logic                     sel_ff, sel_in;
   logic                     valid_ff, valid_in;
   btok_pkg::scan_token_type tok_ff, tok_in;
   logic                     last_ff, last_in;
   logic                     load, take;

   assign load = !valid_ff || out_pop;
   assign take = load && !q_status.empty;

   always_comb begin
      sel_in   = sel_ff;
      valid_in = valid_ff;
      tok_in   = tok_ff;
      last_in  = last_ff;
      q_pop    = 1'b0;
      if (load) begin
         valid_in = !q_status.empty;
      end
      if (take) begin
         tok_in  = sel_ff ? head_rec.tok_b : head_rec.tok_a;
         last_in = !(head_rec.two && !sel_ff);
         sel_in  = head_rec.two && !sel_ff;
         q_pop   = !(head_rec.two && !sel_ff);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         sel_ff   <= 1'b0;
         valid_ff <= 1'b0;
      end else begin
         sel_ff   <= sel_in;
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      tok_ff  <= tok_in;
      last_ff <= last_in;
   end

   assign out_valid = valid_ff;
   assign out_tok   = tok_ff;
   assign out_last  = last_ff;

endmodule

/* test/testbench.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Token scanner regression
// Streams Tiny BASIC source text through the scanner and compares every token
// with a cycle-free prediction, under random idling and back-pressure.
// ----------------------------------------------------------------------------
module testbench;

   // The scoreboard predicts the tokens that each source byte gives and checks
   // every token read back from the scanner against the oldest prediction.
   class scan_checker_type;
      typedef struct {
         logic [4:0]  code;
         logic [30:0] value;
         logic        overflow;
         logic        last;
      } token_record_type;

      token_record_type awaited_tokens[$];
      token_record_type byte_tokens[$];
      int failures = 0;
      int requests_seen = 0;
      int tokens_seen = 0;
      int keyword_hits = 0;
      int clipped_hits = 0;
      int error_hits = 0;

      string keyword_text[12] = '{"PRINT", "IF", "THEN", "GOTO", "INPUT", "LET",
                                  "GOSUB", "RETURN", "CLEAR", "LIST", "RUN", "END"};

      // Scanner state as the scoreboard sees it.
      btok_pkg::scan_mode_type mode = btok_pkg::MODE_IDLE;
      logic [7:0]  word_buf[6];
      logic [2:0]  word_len = '0;
      logic [4:0]  initial_letter = '0;
      logic [30:0] literal_value = '0;
      logic        number_clipped = 1'b0;
      logic [8:0]  text_length = '0;

      function bit is_letter(logic [7:0] c);
         return (c >= "A" && c <= "Z") || (c >= "a" && c <= "z");
      endfunction

      function bit is_digit(logic [7:0] c);
         return c >= "0" && c <= "9";
      endfunction

      function logic [7:0] upcase(logic [7:0] c);
         return (c >= "a" && c <= "z") ? c - btok_pkg::CASE_GAP : c;
      endfunction

      // A byte never gives more than two tokens.
      function void add_token(logic [4:0] code, logic [30:0] value, logic ovf);
         token_record_type t;
         t.code = code;
         t.value = value;
         t.overflow = ovf;
         t.last = 1'b0;
         if (byte_tokens.size() < 2)
            byte_tokens.push_back(t);
      endfunction

      function void close_word();
         logic [4:0] code;
         bit same;
         code = btok_pkg::TK_IDENT;
         for (int k = 0; k < 12; k++) begin
            if (code == btok_pkg::TK_IDENT && word_len == keyword_text[k].len()) begin
               same = 1'b1;
               for (int m = 0; m < keyword_text[k].len(); m++)
                  if (word_buf[m] != keyword_text[k][m])
                     same = 1'b0;
               if (same)
                  code = 5'(btok_pkg::TK_PRINT + k);
            end
         end
         add_token(code, (code == btok_pkg::TK_IDENT) ? {26'd0, initial_letter} : 31'd0,
                   1'b0);
      endfunction

      function void begin_token(logic [7:0] c);
         case (c)
            btok_pkg::CH_SPACE, btok_pkg::CH_TAB: ;
            btok_pkg::CH_NL:     add_token(btok_pkg::TK_EOL, '0, 1'b0);
            btok_pkg::CH_LESS:   mode = btok_pkg::MODE_LT;
            btok_pkg::CH_GREAT:  mode = btok_pkg::MODE_GT;
            btok_pkg::CH_EQUAL:  add_token(btok_pkg::TK_EQ, '0, 1'b0);
            btok_pkg::CH_PLUS:   add_token(btok_pkg::TK_PLUS, '0, 1'b0);
            btok_pkg::CH_MINUS:  add_token(btok_pkg::TK_MINUS, '0, 1'b0);
            btok_pkg::CH_STAR:   add_token(btok_pkg::TK_MUL, '0, 1'b0);
            btok_pkg::CH_SLASH:  add_token(btok_pkg::TK_DIV, '0, 1'b0);
            btok_pkg::CH_LPAREN: add_token(btok_pkg::TK_LPAREN, '0, 1'b0);
            btok_pkg::CH_RPAREN: add_token(btok_pkg::TK_RPAREN, '0, 1'b0);
            btok_pkg::CH_COMMA:  add_token(btok_pkg::TK_COMMA, '0, 1'b0);
            btok_pkg::CH_QUOTE: begin
               mode = btok_pkg::MODE_STR;
               text_length = '0;
            end
            default: begin
               if (is_letter(c)) begin
                  mode = btok_pkg::MODE_WORD;
                  word_buf[0] = upcase(c);
                  word_len = 3'd1;
                  initial_letter = 5'(upcase(c) - btok_pkg::CH_UPPER_A);
               end else if (is_digit(c)) begin
                  mode = btok_pkg::MODE_NUM;
                  literal_value = 31'(c - btok_pkg::CH_ZERO);
                  number_clipped = 1'b0;
               end else begin
                  add_token(btok_pkg::TK_ERROR, {23'd0, c}, 1'b0);
               end
            end
         endcase
      endfunction

      // Called for every source byte the scanner accepts.
      function void note_request(logic [7:0] c);
         bit again;
         logic [34:0] wide;
         again = 1'b0;
         byte_tokens.delete();
         requests_seen++;
         case (mode)
            btok_pkg::MODE_LT: begin
               mode = btok_pkg::MODE_IDLE;
               if (c == btok_pkg::CH_EQUAL)
                  add_token(btok_pkg::TK_LE, '0, 1'b0);
               else if (c == btok_pkg::CH_GREAT)
                  add_token(btok_pkg::TK_NE, '0, 1'b0);
               else begin
                  add_token(btok_pkg::TK_LT, '0, 1'b0);
                  again = 1'b1;
               end
            end
            btok_pkg::MODE_GT: begin
               mode = btok_pkg::MODE_IDLE;
               if (c == btok_pkg::CH_EQUAL)
                  add_token(btok_pkg::TK_GE, '0, 1'b0);
               else begin
                  add_token(btok_pkg::TK_GT, '0, 1'b0);
                  again = 1'b1;
               end
            end
            btok_pkg::MODE_WORD: begin
               if (is_letter(c) || is_digit(c)) begin
                  if (word_len < 3'd6) begin
                     word_buf[word_len] = upcase(c);
                     word_len++;
                  end else begin
                     word_len = btok_pkg::WORD_TOO_LONG;
                  end
               end else begin
                  close_word();
                  mode = btok_pkg::MODE_IDLE;
                  again = 1'b1;
               end
            end
            btok_pkg::MODE_NUM: begin
               if (is_digit(c)) begin
                  wide = 35'(literal_value) * 35'd10 + 35'(c - btok_pkg::CH_ZERO);
                  if (wide > 35'(btok_pkg::NUM_MAX)) begin
                     literal_value = btok_pkg::NUM_MAX;
                     number_clipped = 1'b1;
                  end else begin
                     literal_value = wide[30:0];
                  end
               end else begin
                  add_token(btok_pkg::TK_INT, literal_value, number_clipped);
                  mode = btok_pkg::MODE_IDLE;
                  again = 1'b1;
               end
            end
            btok_pkg::MODE_STR: begin
               if (c == btok_pkg::CH_QUOTE) begin
                  add_token(btok_pkg::TK_STREND, {22'd0, text_length}, 1'b0);
                  mode = btok_pkg::MODE_IDLE;
               end else if (c == btok_pkg::CH_NL) begin
                  add_token(btok_pkg::TK_ERROR, {22'd0, text_length}, 1'b0);
                  add_token(btok_pkg::TK_EOL, '0, 1'b0);
                  mode = btok_pkg::MODE_IDLE;
               end else begin
                  add_token(btok_pkg::TK_STRCH, {23'd0, c}, 1'b0);
                  if (text_length < btok_pkg::STR_CAP)
                     text_length++;
               end
            end
            default: begin
               mode = btok_pkg::MODE_IDLE;
               again = 1'b1;
            end
         endcase
         if (again)
            begin_token(c);
         if (byte_tokens.size() > 0)
            byte_tokens[byte_tokens.size() - 1].last = 1'b1;
         foreach (byte_tokens[i])
            awaited_tokens.push_back(byte_tokens[i]);
      endfunction

      // Called for every token the scanner hands over.
      function void check_token(logic [4:0] code, logic [30:0] value, logic ovf,
                                logic last);
         token_record_type want;
         tokens_seen++;
         if (awaited_tokens.size() == 0) begin
            failures++;
            if (failures <= 10)
               $display("token %0d: none awaited, got code %0d value %0d ovf %0b last %0b",
                        tokens_seen, code, value, ovf, last);
            return;
         end
         want = awaited_tokens.pop_front();
         if (code !== want.code || value !== want.value || ovf !== want.overflow ||
             last !== want.last) begin
            failures++;
            if (failures <= 10) begin
               $display("token %0d: expected code %0d value %0d ovf %0b last %0b",
                        tokens_seen, want.code, want.value, want.overflow, want.last);
               $display("   got code %0d value %0d ovf %0b last %0b",
                        code, value, ovf, last);
            end
         end
         if (want.code >= btok_pkg::TK_PRINT && want.code < btok_pkg::TK_GT)
            keyword_hits++;
         if (want.overflow)
            clipped_hits++;
         if (want.code == btok_pkg::TK_ERROR)
            error_hits++;
      endfunction
   endclass

   // All inputs start from known values; reset is held until the main sequence releases it.
   logic        clock;
   logic        reset = 1'b1;
   logic        req_push = 1'b0;
   logic        req_full;
   logic [7:0]  req_ch = 8'h00;
   logic        rsp_empty;
   logic        rsp_pop = 1'b0;
   logic [4:0]  rsp_token_code;
   logic [30:0] rsp_token_value;
   logic        rsp_overflow;
   logic        rsp_last;

   scan_checker_type board;
   logic [7:0]  source_text[$];
   // Set once the sender reaches the closing stretch, where nobody idles.
   bit          calm_phase = 1'b0;

   localparam int HOLD_OFF_CYCLES = 150;

   basic_token_scanner_unit dut (
      .clock           (clock),
      .reset           (reset),
      .req_push        (req_push),
      .req_full        (req_full),
      .req_ch          (req_ch),
      .rsp_empty       (rsp_empty),
      .rsp_pop         (rsp_pop),
      .rsp_token_code  (rsp_token_code),
      .rsp_token_value (rsp_token_value),
      .rsp_overflow    (rsp_overflow),
      .rsp_last        (rsp_last)
   );

   initial begin
      clock = 1'b0;
      forever #4 clock = ~clock;
   end

   // ------------------------------------------------------------------------
   // Source text generation. Most of the text is well-formed lines of
   // keywords, names, numbers, operators and strings with random spacing, so
   // that the scanner spends its time in the word, number and string states;
   // some lines are plain noise bytes.
   // ------------------------------------------------------------------------
   function automatic void add_text(string s);
      for (int i = 0; i < s.len(); i++)
         source_text.push_back(s[i]);
   endfunction

   // Letters come out in either case at random.
   function automatic void add_letter(logic [7:0] upper);
      source_text.push_back($urandom_range(0, 1) ? upper + btok_pkg::CASE_GAP : upper);
   endfunction

   // No gap at all is common, so that one token often ends another.
   function automatic void add_gap();
      repeat ($urandom_range(0, 2))
         source_text.push_back($urandom_range(0, 1) ? btok_pkg::CH_SPACE : btok_pkg::CH_TAB);
   endfunction

   function automatic void add_keyword(int k);
      string word = board.keyword_text[k];
      for (int i = 0; i < word.len(); i++)
         add_letter(word[i]);
   endfunction

   // Names run up to nine characters, so long words appear regularly.
   function automatic void add_name();
      int pick;
      add_letter(8'(btok_pkg::CH_UPPER_A + $urandom_range(0, 25)));
      repeat ($urandom_range(0, 8)) begin
         pick = $urandom_range(0, 35);
         if (pick < 26)
            add_letter(8'(btok_pkg::CH_UPPER_A + pick));
         else
            source_text.push_back(8'(btok_pkg::CH_ZERO + pick - 26));
      end
   endfunction

   function automatic void add_number(int digits);
      repeat (digits)
         source_text.push_back(8'(btok_pkg::CH_ZERO + $urandom_range(0, 9)));
   endfunction

   // String bodies take any byte but the quote and the newline.
   function automatic void add_string(int length, bit closed);
      logic [7:0] c;
      source_text.push_back(btok_pkg::CH_QUOTE);
      repeat (length) begin
         do
            c = 8'($urandom_range(0, 255));
         while (c == btok_pkg::CH_QUOTE || c == btok_pkg::CH_NL);
         source_text.push_back(c);
      end
      source_text.push_back(closed ? btok_pkg::CH_QUOTE : btok_pkg::CH_NL);
   endfunction

   function automatic void add_operator();
      string ops = "<>=+-*/(),";
      logic [7:0] c = ops[$urandom_range(0, ops.len() - 1)];
      source_text.push_back(c);
      if ((c == btok_pkg::CH_LESS || c == btok_pkg::CH_GREAT) && $urandom_range(0, 1))
         source_text.push_back($urandom_range(0, 1) ? btok_pkg::CH_EQUAL
                                                    : btok_pkg::CH_GREAT);
   endfunction

   function automatic void add_line();
      if ($urandom_range(0, 9) == 0) begin
         repeat ($urandom_range(1, 6))
            source_text.push_back(8'($urandom_range(0, 255)));
      end else begin
         repeat ($urandom_range(1, 8)) begin
            case ($urandom_range(0, 5))
               0: add_keyword($urandom_range(0, 11));
               1: add_name();
               2: add_number(($urandom_range(0, 5) == 0) ? $urandom_range(10, 14)
                                                         : $urandom_range(1, 4));
               4: add_string($urandom_range(0, 6), $urandom_range(0, 7) != 0);
               default: add_operator();
            endcase
            add_gap();
         end
      end
      source_text.push_back(btok_pkg::CH_NL);
   endfunction

   function automatic void build_source();
      int order[12];
      int j;
      int swap;
      // Directed opening: every operator, the lookahead pairs with a byte that
      // must be looked at again, a short string, a carriage return and the
      // lowest and highest byte as bad bytes, and a string cut off by newline.
      add_text("<=<>>=<a>1=+-*/(),\"Q\"");
      source_text.push_back(8'h0D);
      source_text.push_back(8'h00);
      source_text.push_back(8'hFF);
      add_text("\"z\n\t\n");
      // First random line: all twelve keywords in random order and case, a
      // saturating integer, and a string long enough to cap its length.
      foreach (order[i])
         order[i] = i;
      for (int i = 11; i > 0; i--) begin
         j = $urandom_range(0, i);
         swap = order[i];
         order[i] = order[j];
         order[j] = swap;
      end
      foreach (order[i]) begin
         add_keyword(order[i]);
         source_text.push_back(btok_pkg::CH_SPACE);
      end
      add_number(12);
      add_string($urandom_range(256, 300), 1'b1);
      source_text.push_back(btok_pkg::CH_NL);
      while (source_text.size() < 930)
         add_line();
   endfunction

   // ------------------------------------------------------------------------
   // Sender: offers the source text one request at a time, with random idle
   // bursts until the closing stretch.
   // ------------------------------------------------------------------------
   task automatic feed_source();
      for (int i = 0; i < source_text.size(); i++) begin
         if (i >= source_text.size() - 120)
            calm_phase = 1'b1;
         if (!calm_phase && $urandom_range(0, 9) == 0) begin
            req_push <= 1'b0;
            repeat ($urandom_range(1, 10)) @(posedge clock);
         end
         req_ch   <= source_text[i];
         req_push <= 1'b1;
         do
            @(posedge clock);
         while (req_full);
         board.note_request(source_text[i]);
      end
      req_push <= 1'b0;
   endtask

   // ------------------------------------------------------------------------
   // Receiver: pops tokens, idling in random bursts. Once, early in the run,
   // it holds off for a long stretch so that the record queue fills and the
   // scanner has to refuse requests.
   // ------------------------------------------------------------------------
   initial begin
      int hold_count;
      bit held;
      held = 1'b0;
      while (reset)
         @(posedge clock);
      forever begin
         if (!held && board.tokens_seen >= 40) begin
            held = 1'b1;
            rsp_pop <= 1'b0;
            for (hold_count = 0; hold_count < HOLD_OFF_CYCLES; hold_count++)
               @(posedge clock);
         end else if (!calm_phase && $urandom_range(0, 11) == 0) begin
            rsp_pop <= 1'b0;
            repeat ($urandom_range(1, 10)) @(posedge clock);
         end
         rsp_pop <= 1'b1;
         @(posedge clock);
         if (!rsp_empty)
            board.check_token(rsp_token_code, rsp_token_value, rsp_overflow, rsp_last);
      end
   end

   // ------------------------------------------------------------------------
   // Main sequence. After the last request has been taken the run waits for
   // every awaited token, then a little longer so that a stray extra token
   // would still be caught.
   // ------------------------------------------------------------------------
   initial begin
      board = new();
      repeat (2) @(posedge clock);
      reset <= 1'b0;
      build_source();
      feed_source();
      while (board.awaited_tokens.size() != 0)
         @(posedge clock);
      repeat (16) @(posedge clock);
      $display("Scanned %0d source bytes into %0d tokens: %0d keywords,",
               board.requests_seen, board.tokens_seen, board.keyword_hits);
      $display("%0d saturated integers, %0d error tokens.",
               board.clipped_hits, board.error_hits);
      $display("Random idling on both sides, one %0d-cycle reader hold-off, %0d mismatches.",
               HOLD_OFF_CYCLES, board.failures);
      if (board.failures == 0)
         $display("basic_token_scanner_unit regression: pass");
      else
         $display("basic_token_scanner_unit regression: fail");
      $finish;
   end

   // Safety net in case the scanner stops answering.
   initial begin
      #4_000_000;
      $display("Timed out with %0d tokens still awaited.", board.awaited_tokens.size());
      $display("basic_token_scanner_unit regression: fail");
      $finish;
   end

endmodule

/* sim.f */
rtl/core/btok_pkg.sv
rtl/core/btok_front.sv
rtl/core/btok_queue.sv
rtl/core/btok_back.sv
rtl/core/basic_token_scanner_unit.sv
test/testbench.sv
